// ===== hdl/u8san_pkg.sv =====
package u8san_pkg;

    // Depth of the job queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Byte classes.
    localparam logic [7:0] ASCII_LIMIT   = 8'h80;
    localparam logic [7:0] LEAD2_MASK    = 8'hE0;
    localparam logic [7:0] LEAD2_CODE    = 8'hC0;
    localparam logic [7:0] LEAD3_MASK    = 8'hF0;
    localparam logic [7:0] LEAD3_CODE    = 8'hE0;
    localparam logic [7:0] LEAD4_MASK    = 8'hF8;
    localparam logic [7:0] LEAD4_CODE    = 8'hF0;
    localparam logic [1:0] CONT_TAG      = 2'b10;

    // Code point limits.
    localparam logic [20:0] MIN_CP2      = 21'h00080;
    localparam logic [20:0] MIN_CP3      = 21'h00800;
    localparam logic [20:0] MIN_CP4      = 21'h10000;
    localparam logic [20:0] MAX_CP       = 21'h10FFFF;
    localparam logic [20:0] SURR_LOW     = 21'h0D800;
    localparam logic [20:0] SURR_HIGH    = 21'h0DFFF;

    // Sequence lengths.
    localparam logic [2:0] SEQ_LEN2      = 3'd2;
    localparam logic [2:0] SEQ_LEN3      = 3'd3;
    localparam logic [2:0] SEQ_LEN4      = 3'd4;

    // Bytes of the replacement character U+FFFD.
    localparam logic [7:0] REP_BYTE0     = 8'hEF;
    localparam logic [7:0] REP_BYTE1     = 8'hBF;
    localparam logic [7:0] REP_BYTE2     = 8'hBD;
    localparam logic [1:0] REP_LAST_IDX  = 2'd2;

    // One output unit: either a raw byte or one whole replacement character.
    typedef struct packed {
        logic [7:0] data;
        logic       rep;
    } unit_t;

    // Work for one input item: up to four units in order.
    typedef struct packed {
        unit_t [3:0] units;
        logic [2:0]  count;
        logic        line_end;
    } job_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    function automatic unit_t raw_unit(input logic [7:0] b);
        unit_t u;
        u.data = b;
        u.rep  = 1'b0;
        return u;
    endfunction

    function automatic unit_t rep_unit();
        unit_t u;
        u.data = 8'h00;
        u.rep  = 1'b1;
        return u;
    endfunction

    function automatic logic [7:0] rep_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = REP_BYTE0;
            2'd1:    b = REP_BYTE1;
            default: b = REP_BYTE2;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/u8san_front.sv =====
module u8san_front
    import u8san_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       byte_present,
    input  logic       line_end,
    output job_t       job,
    output logic       push
);

    logic [7:0]  held_reg [3];
    logic [7:0]  held_next [3];
    logic [1:0]  held_count_reg, held_count_next;
    logic [2:0]  exp_len_reg, exp_len_next;
    logic [20:0] acc_reg, acc_next;

    // Classify the item against the held sequence and build its job.
    always_comb
    begin
        logic [2:0]  k;
        logic        done;
        logic        ok;
        logic [20:0] minimum;
        unit_t [3:0] units;

        held_count_next = held_count_reg;
        exp_len_next    = exp_len_reg;
        acc_next        = acc_reg;
        for (int i = 0; i < 3; i++)
        begin
            held_next[i] = held_reg[i];
        end
        k       = 3'd0;
        done    = 1'b0;
        ok      = 1'b0;
        minimum = MIN_CP4;
        units   = '0;

        if (byte_present)
        begin
            if (held_count_next != 2'd0)
            begin
                if (in_byte[7:6] == CONT_TAG)
                begin
                    acc_next = {acc_next[14:0], in_byte[5:0]};
                    if (({1'b0, held_count_next} + 3'd1) >= exp_len_next)
                    begin
                        // Sequence complete: copy it out or replace each byte.
                        case (exp_len_next)
                            SEQ_LEN2: minimum = MIN_CP2;
                            SEQ_LEN3: minimum = MIN_CP3;
                            default:  minimum = MIN_CP4;
                        endcase
                        ok = (acc_next >= minimum) && (acc_next <= MAX_CP) &&
                             !((acc_next >= SURR_LOW) && (acc_next <= SURR_HIGH));
                        for (int i = 0; i < 3; i++)
                        begin
                            if (held_count_next > 2'(i))
                            begin
                                units[k[1:0]] = ok ? raw_unit(held_reg[i]) : rep_unit();
                                k = k + 3'd1;
                            end
                        end
                        units[k[1:0]] = ok ? raw_unit(in_byte) : rep_unit();
                        k = k + 3'd1;
                        held_count_next = 2'd0;
                        exp_len_next    = 3'd0;
                        acc_next        = '0;
                    end
                    else
                    begin
                        held_next[held_count_next] = in_byte;
                        held_count_next = held_count_next + 2'd1;
                    end
                    done = 1'b1;
                end
                else
                begin
                    // Broken sequence: every held byte becomes a replacement.
                    for (int i = 0; i < 3; i++)
                    begin
                        if (held_count_next > 2'(i))
                        begin
                            units[k[1:0]] = rep_unit();
                            k = k + 3'd1;
                        end
                    end
                    held_count_next = 2'd0;
                    exp_len_next    = 3'd0;
                    acc_next        = '0;
                end
            end

            // Fresh byte: pass ASCII, hold a lead, replace anything else.
            if (!done)
            begin
                if (in_byte < ASCII_LIMIT)
                begin
                    units[k[1:0]] = raw_unit(in_byte);
                    k = k + 3'd1;
                end
                else if ((in_byte & LEAD2_MASK) == LEAD2_CODE)
                begin
                    held_next[0]    = in_byte;
                    held_count_next = 2'd1;
                    exp_len_next    = SEQ_LEN2;
                    acc_next        = {16'd0, in_byte[4:0]};
                end
                else if ((in_byte & LEAD3_MASK) == LEAD3_CODE)
                begin
                    held_next[0]    = in_byte;
                    held_count_next = 2'd1;
                    exp_len_next    = SEQ_LEN3;
                    acc_next        = {17'd0, in_byte[3:0]};
                end
                else if ((in_byte & LEAD4_MASK) == LEAD4_CODE)
                begin
                    held_next[0]    = in_byte;
                    held_count_next = 2'd1;
                    exp_len_next    = SEQ_LEN4;
                    acc_next        = {18'd0, in_byte[2:0]};
                end
                else
                begin
                    units[k[1:0]] = rep_unit();
                    k = k + 3'd1;
                end
            end
        end

        // Line end flushes whatever is still held.
        if (line_end)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (held_count_next > 2'(i))
                begin
                    units[k[1:0]] = rep_unit();
                    k = k + 3'd1;
                end
            end
            held_count_next = 2'd0;
            exp_len_next    = 3'd0;
            acc_next        = '0;
        end

        job.units    = units;
        job.count    = k;
        job.line_end = line_end;
    end

    assign push = accept && (job.count != 3'd0);

    // Sequence control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            exp_len_reg    <= 3'd0;
            acc_reg        <= '0;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
            exp_len_reg    <= exp_len_next;
            acc_reg        <= acc_next;
        end
    end

    // Held bytes carry no reset; only entries below the count are read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                held_reg[i] <= held_next[i];
            end
        end
    end

endmodule

// ===== hdl/u8san_queue.sv =====
module u8san_queue
    import u8san_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      head_job,
    output q_status_t status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t            q_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == CW'(DEPTH));
    assign head_job     = q_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hdl/u8san_back.sv =====
module u8san_back
    import u8san_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       head_job,
    input  q_status_t  status,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       is_replacement,
    output logic       run_last,
    output logic       line_last
);

    logic [1:0] unit_idx_reg, unit_idx_next;
    logic [1:0] sub_idx_reg, sub_idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       rep_reg, rep_next;
    logic       run_last_reg, run_last_next;
    logic       line_last_reg, line_last_next;
    logic       load;
    logic       unit_last;
    logic       job_last;
    unit_t      cur_unit;

    // The output register takes a new byte when it is empty or being drained.
    assign load      = !status.empty && (!valid_reg || !out_stall);
    assign cur_unit  = head_job.units[unit_idx_reg];
    assign unit_last = !cur_unit.rep || (sub_idx_reg == REP_LAST_IDX);
    assign job_last  = unit_last && (({1'b0, unit_idx_reg} + 3'd1) == head_job.count);
    assign pop       = load && job_last;

    // Next output byte and position within the job.
    always_comb
    begin
        unit_idx_next  = unit_idx_reg;
        sub_idx_next   = sub_idx_reg;
        valid_next     = valid_reg && out_stall;
        byte_next      = byte_reg;
        rep_next       = rep_reg;
        run_last_next  = run_last_reg;
        line_last_next = line_last_reg;
        if (load)
        begin
            valid_next     = 1'b1;
            byte_next      = cur_unit.rep ? rep_byte(sub_idx_reg) : cur_unit.data;
            rep_next       = cur_unit.rep;
            run_last_next  = job_last;
            line_last_next = job_last && head_job.line_end;
            if (unit_last)
            begin
                sub_idx_next  = 2'd0;
                unit_idx_next = job_last ? 2'd0 : unit_idx_reg + 2'd1;
            end
            else
            begin
                sub_idx_next = sub_idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_idx_reg <= 2'd0;
            sub_idx_reg  <= 2'd0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            unit_idx_reg <= unit_idx_next;
            sub_idx_reg  <= sub_idx_next;
            valid_reg    <= valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        rep_reg       <= rep_next;
        run_last_reg  <= run_last_next;
        line_last_reg <= line_last_next;
    end

    assign out_valid      = valid_reg;
    assign out_byte       = byte_reg;
    assign is_replacement = rep_reg;
    assign run_last       = run_last_reg;
    assign line_last      = line_last_reg;

endmodule

// ===== hdl/utf8_sanitizer.sv =====
// Path: with the queue empty, an item's job is written into the job queue and then
// its first byte into the output register, from which it is offered.
// Throughput: one input item per cycle while each item yields at most one byte and
// the output does not stall; an item yielding more bytes (up to 12) holds the single
// output register until they have left; a two-job queue lets input run ahead meanwhile.
// Reset: queue, output valid and sequence state are cleared; held bytes are not.
module utf8_sanitizer
    import u8san_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       byte_present,
    input  logic       line_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       is_replacement,
    output logic       run_last,
    output logic       line_last
);

    job_t      front_job;
    job_t      head_job;
    q_status_t q_status;
    logic      push;
    logic      pop;
    logic      accept;

    // Input transfers stop only when the job queue is full.
    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    u8san_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (in_byte),
        .byte_present (byte_present),
        .line_end     (line_end),
        .job          (front_job),
        .push         (push)
    );

    u8san_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (front_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    u8san_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_job       (head_job),
        .status         (q_status),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .is_replacement (is_replacement),
        .run_last       (run_last),
        .line_last      (line_last)
    );

endmodule

// ===== tb/sv/utf8_repl_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the sanitizer, predicts the byte stream for every
// accepted input transfer and compares each output transfer in order.
module utf8_repl_checker
    import u8san_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       byte_present,
    input  logic       line_end,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    input  logic       is_replacement,
    input  logic       run_last,
    input  logic       line_last,
    output int         fail_count,
    output int         outstanding
);

    typedef struct packed {
        logic [7:0] data;
        logic       rep;
        logic       item_last;
        logic       line_last;
    } san_byte_t;

    // Bytes still to come from the block, oldest first.
    san_byte_t   pending_bytes[$];
    // Bytes produced by the item being predicted.
    san_byte_t   item_bytes[$];

    // Predictor copy of the sequence state.
    logic [7:0]  held_seq [3];
    logic [1:0]  held_cnt;
    logic [2:0]  seq_len;
    logic [20:0] code_pt;
    int          result_idx;

    task automatic emit(input logic [7:0] d, input logic r);
        item_bytes.insert(item_bytes.size(), '{d, r, 1'b0, 1'b0});
    endtask

    task automatic emit_fffd();
        emit(REP_BYTE0, 1'b1);
        emit(REP_BYTE1, 1'b1);
        emit(REP_BYTE2, 1'b1);
    endtask

    task automatic clear_seq();
        held_cnt = 2'd0;
        seq_len  = 3'd0;
        code_pt  = 21'd0;
    endtask

    // Every held byte turns into one replacement character.
    task automatic flush_seq();
        for (int i = 0; i < held_cnt; i++)
            emit_fffd();
        clear_seq();
    endtask

    // A byte with nothing held: ASCII passes, a lead opens a sequence, anything else is replaced.
    task automatic open_seq(input logic [7:0] b);
        if (b < ASCII_LIMIT)
            emit(b, 1'b0);
        else if ((b & LEAD2_MASK) == LEAD2_CODE)
        begin
            held_seq[0] = b;
            held_cnt    = 2'd1;
            seq_len     = SEQ_LEN2;
            code_pt     = {16'd0, b[4:0]};
        end
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
        begin
            held_seq[0] = b;
            held_cnt    = 2'd1;
            seq_len     = SEQ_LEN3;
            code_pt     = {17'd0, b[3:0]};
        end
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
        begin
            held_seq[0] = b;
            held_cnt    = 2'd1;
            seq_len     = SEQ_LEN4;
            code_pt     = {18'd0, b[2:0]};
        end
        else
            emit_fffd();
    endtask

    // The final continuation byte has arrived: copy the sequence or replace it.
    task automatic close_seq(input logic [7:0] b);
        logic [20:0] min_cp;
        logic        legal;
        case (seq_len)
            SEQ_LEN2: min_cp = MIN_CP2;
            SEQ_LEN3: min_cp = MIN_CP3;
            default:  min_cp = MIN_CP4;
        endcase
        legal = (code_pt >= min_cp) && (code_pt <= MAX_CP) &&
                !((code_pt >= SURR_LOW) && (code_pt <= SURR_HIGH));
        for (int i = 0; i < held_cnt; i++)
        begin
            if (legal)
                emit(held_seq[i], 1'b0);
            else
                emit_fffd();
        end
        if (legal)
            emit(b, 1'b0);
        else
            emit_fffd();
        clear_seq();
    endtask

    // Works out the output bytes of one input transfer.
    task automatic sanitize_item(input logic [7:0] b, input logic present,
                                 input logic lend);
        logic taken;
        taken = 1'b0;
        item_bytes.delete();
        if (present)
        begin
            if (held_cnt != 2'd0)
            begin
                if (b[7:6] == CONT_TAG)
                begin
                    code_pt = {code_pt[14:0], b[5:0]};
                    if (held_cnt + 1 >= seq_len)
                        close_seq(b);
                    else if (held_cnt < 2'd3)
                    begin
                        held_seq[held_cnt] = b;
                        held_cnt = held_cnt + 2'd1;
                    end
                    taken = 1'b1;
                end
                else
                    flush_seq();
            end
            if (!taken)
                open_seq(b);
        end
        if (lend)
            flush_seq();
        if (item_bytes.size() > 0)
        begin
            item_bytes[item_bytes.size() - 1].item_last = 1'b1;
            item_bytes[item_bytes.size() - 1].line_last = lend;
        end
        foreach (item_bytes[i])
            pending_bytes.insert(pending_bytes.size(), item_bytes[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        san_byte_t want;
        if (!rst_n)
        begin
            pending_bytes.delete();
            clear_seq();
            result_idx  = 0;
            fail_count  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                sanitize_item(in_byte, byte_present, line_end);

            // Compare one output transfer against the oldest prediction.
            if (out_valid && !out_stall)
            begin
                if (pending_bytes.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("Unexpected output %0d: got %h/%b/%b/%b",
                                 result_idx, out_byte, is_replacement, run_last,
                                 line_last);
                    fail_count++;
                end
                else
                begin
                    want = pending_bytes[0];
                    pending_bytes.delete(0);
                    if (want.data !== out_byte || want.rep !== is_replacement ||
                        want.item_last !== run_last || want.line_last !== line_last)
                    begin
                        if (fail_count < 10)
                            $display("Mismatch at output %0d: exp %h/%b/%b/%b got %h/%b/%b/%b",
                                     result_idx, want.data, want.rep, want.item_last,
                                     want.line_last, out_byte, is_replacement, run_last,
                                     line_last);
                        fail_count++;
                    end
                end
                result_idx++;
            end
            outstanding <= pending_bytes.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench
    import u8san_pkg::*;
();

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       byte_present;
    logic       line_end;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       is_replacement;
    logic       run_last;
    logic       line_last;

    int         fail_count;
    int         outstanding;
    int         item_cnt;
    int         burst_until;
    logic       tx_idle_en;
    logic       rx_idle_en;
    logic       hold_req;
    logic       hold_done;
    logic       drain_done;

    utf8_sanitizer i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .byte_present   (byte_present),
        .line_end       (line_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .is_replacement (is_replacement),
        .run_last       (run_last),
        .line_last      (line_last)
    );

    utf8_repl_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .byte_present   (byte_present),
        .line_end       (line_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .is_replacement (is_replacement),
        .run_last       (run_last),
        .line_last      (line_last),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Output side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        logic hold_taken;
        hold_taken = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_stall <= 1'b1;
                repeat (80) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if (rx_idle_en && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // Offers one item, with an optional idle gap first, and waits for its transfer.
    task automatic send_item(input logic [7:0] b, input logic present, input logic lend);
        if (tx_idle_en && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_byte      <= b;
        byte_present <= present;
        line_end     <= lend;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        item_cnt++;
    endtask

    // Holds the input idle until every predicted byte has left the block.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // A well-formed encoding of a random code point; some are overlong,
    // surrogates or above the Unicode range.
    task automatic send_char();
        logic [20:0] cp;
        logic [7:0]  enc [4];
        int          len;
        logic        lend;
        len = $urandom_range(1, 4);
        case (len)
            1:
            begin
                cp     = 21'($urandom_range(0, 'h7F));
                enc[0] = {1'b0, cp[6:0]};
            end
            2:
            begin
                cp     = 21'($urandom_range(0, 'h7FF));
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {CONT_TAG, cp[5:0]};
            end
            3:
            begin
                cp     = 21'($urandom_range(0, 'hFFFF));
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {CONT_TAG, cp[11:6]};
                enc[2] = {CONT_TAG, cp[5:0]};
            end
            default:
            begin
                cp     = 21'($urandom_range(0, 'h13FFFF));
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {CONT_TAG, cp[17:12]};
                enc[2] = {CONT_TAG, cp[11:6]};
                enc[3] = {CONT_TAG, cp[5:0]};
            end
        endcase
        lend = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++)
            send_item(enc[i], 1'b1, (i == len - 1) ? lend : 1'b0);
    endtask

    // A byte from C0 to FF followed by zero to three continuations, which may or may not complete it.
    task automatic send_broken();
        int   n;
        logic lend;
        n    = $urandom_range(0, 3);
        lend = ($urandom_range(0, 5) == 0);
        send_item(8'($urandom_range('hC0, 'hFF)), 1'b1, (n == 0) ? lend : 1'b0);
        for (int i = 0; i < n; i++)
            send_item(8'($urandom_range('h80, 'hBF)), 1'b1, (i == n - 1) ? lend : 1'b0);
    endtask

    initial
    begin
        int kind;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_byte      <= 8'h00;
        byte_present <= 1'b0;
        line_end     <= 1'b0;
        item_cnt     = 0;
        burst_until  = 0;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        hold_req     = 1'b0;
        hold_done    = 1'b0;
        drain_done   = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ASCII extremes, the second one ending a line.
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b1);
        // Stray continuation and invalid lead bytes.
        send_item(8'hBF, 1'b1, 1'b0);
        send_item(8'hF8, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        // Overlong two-byte form from an out-of-range lead.
        send_item(8'hC1, 1'b1, 1'b0);
        send_item(8'hBF, 1'b1, 1'b0);
        // Out-of-range four-byte lead, above the largest code point.
        send_item(8'hF5, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        // Surrogate.
        send_item(8'hED, 1'b1, 1'b0);
        send_item(8'hA0, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        // Legal four-byte sequence.
        send_item(8'hF0, 1'b1, 1'b0);
        send_item(8'h9F, 1'b1, 1'b0);
        send_item(8'h98, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        // Sequence broken by an ASCII byte.
        send_item(8'hE2, 1'b1, 1'b0);
        send_item(8'h41, 1'b1, 1'b0);
        // Lead byte on a line-ending item, then a flush-only line end.
        send_item(8'hE2, 1'b1, 1'b1);
        send_item(8'hC3, 1'b1, 1'b0);
        send_item(8'h55, 1'b0, 1'b1);
        // Empty item, then a line end with nothing held.
        send_item(8'hAA, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);

        // Random part: mostly legal characters, some broken ones and noise.
        while (item_cnt < 370)
        begin
            tx_idle_en = !((item_cnt >= 60 && item_cnt < 110) || item_cnt < burst_until ||
                           item_cnt >= 320);
            rx_idle_en = !((item_cnt >= 60 && item_cnt < 110) || item_cnt >= 320);
            if (item_cnt >= 150 && !hold_done)
            begin
                // Output held off while the input keeps offering items.
                hold_req    = 1'b1;
                hold_done   = 1'b1;
                burst_until = item_cnt + 30;
                tx_idle_en  = 1'b0;
            end
            if (item_cnt >= 250 && !drain_done)
            begin
                wait_drained();
                drain_done = 1'b1;
            end
            kind = $urandom_range(0, 9);
            if (kind < 6)
                send_char();
            else if (kind < 8)
                send_broken();
            else
                send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 5) != 0),
                          ($urandom_range(0, 7) == 0));
        end

        // Let everything drain, then give the verdict.
        wait_drained();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/u8san_pkg.sv
hdl/u8san_front.sv
hdl/u8san_queue.sv
hdl/u8san_back.sv
hdl/utf8_sanitizer.sv
tb/sv/utf8_repl_checker.sv
tb/sv/testbench.sv
